@@ src/pmsac_pkg.sv @@
// ---------------------------------------------------------------------------
// pmsac_pkg: shared types and constants
// Codes, widths and inter-module structs of the MSAC pose scorer.
// ---------------------------------------------------------------------------
`default_nettype none
package pmsac_pkg;

	localparam int Z_W = 52;  // camera coordinate, 32 fractional bits
	localparam int Q_W = 41;  // projection magnitude, Q.24, saturates at 2^40

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_POINT = 2'd2;

	localparam logic [1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_INTERVAL  = 2'd1;
	localparam logic [1:0] CFG_COUNT     = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_MULW,
		S_ZCHK,
		S_DXS,
		S_DXW,
		S_SQX,
		S_DYS,
		S_DYW,
		S_SQY,
		S_SQW,
		S_ACC,
		S_DEC,
		S_FIN
	} state_t;

	typedef struct packed {
		logic             start;
		logic [Z_W-1:0]   num;  // dividend magnitude
		logic [Z_W-1:0]   den;  // divisor, nonzero
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [Q_W-1:0]   q;
	} div_rsp_t;

endpackage
`default_nettype wire

@@ src/pmsac_mul.sv @@
// ---------------------------------------------------------------------------
// pmsac_mul: shared multiplier
// 33x33 signed multiply with a registered product.
// ---------------------------------------------------------------------------
`default_nettype none
module pmsac_mul (
	input  wire logic               clk,
	input  wire logic signed [32:0] a,
	input  wire logic signed [32:0] b,
	output logic signed [65:0]      prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end
endmodule
`default_nettype wire

@@ src/pmsac_div.sv @@
// ---------------------------------------------------------------------------
// pmsac_div: iterative projection divider
// Computes min(floor(num * 2^24 / den), 2^40), one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module pmsac_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pmsac_pkg::div_req_t   req,
	output pmsac_pkg::div_rsp_t        rsp
);
	import pmsac_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [Z_W-1:0]   rem_q;
	logic [Z_W-1:0]   dsr_q;
	logic [39:0]      low_q;
	logic [Q_W-1:0]   quo_q;

	logic [Z_W:0]     trial;
	logic             ge;
	logic             sat;

	assign trial = {rem_q, low_q[39]};
	assign ge    = trial >= {1'b0, dsr_q};
	// quotient would reach 2^40: num >= den * 2^16
	assign sat   = {16'b0, req.num} >= {req.den, 16'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 6'd40;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dsr_q <= req.den;
			rem_q <= {16'b0, req.num[Z_W-1:16]};
			low_q <= {req.num[15:0], 24'b0};
			quo_q <= sat ? {1'b1, {(Q_W-1){1'b0}}} : '0;
		end else if (busy_q) begin
			rem_q <= ge ? Z_W'(trial - {1'b0, dsr_q}) : trial[Z_W-1:0];
			low_q <= {low_q[38:0], 1'b0};
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = quo_q;
endmodule
`default_nettype wire

@@ src/preemptive_msac_pose_scorer_core.sv @@
// ---------------------------------------------------------------------------
// preemptive_msac_pose_scorer_core: MSAC pose hypothesis scorer
// Projects 2D-3D correspondences through [R|t], accumulates truncated cost
// and prunes hopeless hypotheses at block boundaries.
// ---------------------------------------------------------------------------
// Usage: send a start transaction (tuser 0) with the score limit and inlier
// limit, load the twelve pose entries (tuser 1), then stream points
// (tuser 2). Start and load transactions leave the sequencer idle. A point
// runs nine products on the one shared multiplier, two passes of the
// bit-serial divider (x then y projection), two squaring products and
// control steps; s_tready is low meanwhile. A projection that saturates
// leaves the divider without the bit-serial pass. A point with
// non-positive depth skips the divider and the squaring products.
// One result goes out when a pass ends or is pruned; the output register
// holds it while the next items are taken.
`default_nettype none
module preemptive_msac_pose_scorer_core #(
	parameter int MAX_POINTS = 4096
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tdata from bit 0: entry_index[4], value[64], limit_enabled[1],
	// inlier_cap[13], guard_inlier[1], img_x[32], img_y[32],
	// world_x[32], world_y[32], world_z[32], zero pad to 248
	input  wire logic [247:0] s_tdata,
	input  wire logic [1:0]   s_tuser,  // func[2]
	input  wire logic         s_tlast,  // last_point
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tdata from bit 0: score[63], inlier_total[13], points_evaluated[13],
	// zero pad to 96
	output logic [95:0]       m_tdata,
	output logic [0:0]        m_tuser,  // was_pruned[1]
	// configuration writes
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [47:0]  cfg_data
);
	import pmsac_pkg::*;

	// ---------------- configuration ----------------
	logic [47:0] thr_q;
	logic [12:0] civ_q;
	logic [12:0] pcnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			civ_q  <= 13'd1;
			pcnt_q <= 13'd4;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_q  <= cfg_data;
				CFG_INTERVAL:  civ_q  <= cfg_data[12:0];
				CFG_COUNT:     pcnt_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// effective pass length and block length
	logic [12:0] cnt_eff;
	logic [12:0] interval;
	assign cnt_eff  = (32'(pcnt_q) > 32'(MAX_POINTS)) ? 13'(MAX_POINTS) : pcnt_q;
	assign interval = (civ_q == 13'd0) ? 13'd1 : civ_q;

	// ---------------- input field slices ----------------
	logic [3:0]  in_entry;
	logic [63:0] in_value;
	logic        in_limen;
	logic [12:0] in_ilim;
	logic        in_guard;
	logic [31:0] in_img_x, in_img_y, in_wx, in_wy, in_wz;
	assign in_entry = s_tdata[3:0];
	assign in_value = s_tdata[67:4];
	assign in_limen = s_tdata[68];
	assign in_ilim  = s_tdata[81:69];
	assign in_guard = s_tdata[82];
	assign in_img_x = s_tdata[114:83];
	assign in_img_y = s_tdata[146:115];
	assign in_wx    = s_tdata[178:147];
	assign in_wy    = s_tdata[210:179];
	assign in_wz    = s_tdata[242:211];

	// ---------------- state ----------------
	state_t state_q, state_d;

	logic [31:0]           pose_q [12];
	logic [62:0]           cost_q;
	logic [12:0]           inl_q, pts_q, blk_q, cntlim_q;
	logic signed [63:0]    climit_q;
	logic                  en_q, guard_q, closed_q;

	logic [31:0]           img_x_q, img_y_q;
	logic [31:0]           w_q [3];
	logic                  last_q;
	logic signed [Z_W-1:0] z_q [3];
	logic                  zpos_q;
	logic [1:0]            row_q, col_q;
	logic                  tag_v_s1;
	logic [1:0]            tag_row_s1;
	logic                  big_q;
	logic [54:0]           tx_q, ty_q;
	logic                  prune_q;

	logic                  out_valid_q;
	logic [62:0]           out_score_q;
	logic [12:0]           out_inl_q, out_pts_q;
	logic                  out_prune_q;

	logic s_fire;
	assign s_fire = s_tvalid && s_tready;

	// ---------------- shared units ----------------
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;
	div_req_t           dreq;
	div_rsp_t           drsp;

	pmsac_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	pmsac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// residual of the projection currently in the divider
	logic                  axis_y;
	logic                  num_neg;
	logic signed [42:0]    proj;
	logic signed [42:0]    resid;
	logic [42:0]           rmag;
	assign axis_y  = (state_q == S_SQY);
	assign num_neg = axis_y ? z_q[1][Z_W-1] : z_q[0][Z_W-1];
	assign proj    = num_neg ? -$signed({2'b0, drsp.q}) : $signed({2'b0, drsp.q});
	assign resid   = proj - 43'(signed'(axis_y ? img_y_q : img_x_q));
	assign rmag    = resid[42] ? 43'(-resid) : 43'(resid);

	// squared term: saturated magnitudes count as 2^54 (always outlier)
	logic [54:0] term;
	assign term = big_q ? {1'b1, 54'b0} : {1'b0, prod_q[61:8]};

	logic [Z_W-1:0] zmag0, zmag1;
	assign zmag0 = z_q[0][Z_W-1] ? Z_W'(-z_q[0]) : Z_W'(z_q[0]);
	assign zmag1 = z_q[1][Z_W-1] ? Z_W'(-z_q[1]) : Z_W'(z_q[1]);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MUL: begin
				mul_a = {pose_q[{row_q, col_q}][31], pose_q[{row_q, col_q}]};
				mul_b = {w_q[col_q][31], w_q[col_q]};
			end
			S_SQX, S_SQY: begin
				mul_a = {2'b0, rmag[30:0]};
				mul_b = {2'b0, rmag[30:0]};
			end
			default: ;
		endcase
	end

	always_comb begin
		dreq.start = (state_q == S_DXS) || (state_q == S_DYS);
		dreq.num   = (state_q == S_DYS) ? zmag1 : zmag0;
		dreq.den   = Z_W'(z_q[2]);
	end

	// ---------------- cost update (ACC) ----------------
	logic [55:0] rsq;
	logic        inlier;
	logic [55:0] add;
	logic [63:0] csum;
	assign rsq    = {1'b0, tx_q} + {1'b0, ty_q};
	assign inlier = zpos_q && (rsq < {8'b0, thr_q});
	assign add    = inlier ? rsq : {8'b0, thr_q};
	assign csum   = {1'b0, cost_q} + {8'b0, add};

	// ---------------- block boundary decision (DEC) ----------------
	logic        pass_end, boundary, over, guard_ok, prune;
	logic [12:0] left;
	assign pass_end = last_q || (pts_q >= cnt_eff);
	assign boundary = pass_end || (blk_q >= interval);
	assign over     = climit_q[63] || ({1'b0, cost_q} > climit_q);
	assign left     = pass_end ? 13'd0 : 13'(cnt_eff - pts_q);
	assign guard_ok = !guard_q || (({1'b0, inl_q} + {1'b0, left}) <= {1'b0, cntlim_q});
	assign prune    = boundary && en_q && over && guard_ok;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser == FUNC_POINT && !closed_q) state_d = S_MUL;
			end
			S_MUL:  if (row_q == 2'd2 && col_q == 2'd2) state_d = S_MULW;
			S_MULW: state_d = S_ZCHK;
			S_ZCHK: state_d = (!z_q[2][Z_W-1] && z_q[2] != '0) ? S_DXS : S_ACC;
			S_DXS:  state_d = S_DXW;
			S_DXW:  if (drsp.done) state_d = S_SQX;
			S_SQX:  state_d = S_DYS;
			S_DYS:  state_d = S_DYW;
			S_DYW:  if (drsp.done) state_d = S_SQY;
			S_SQY:  state_d = S_SQW;
			S_SQW:  state_d = S_ACC;
			S_ACC:  state_d = S_DEC;
			S_DEC:  state_d = (boundary && (prune || pass_end)) ? S_FIN : S_IDLE;
			S_FIN:  if (!out_valid_q || m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- pass control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 12; i++) pose_q[i] <= '0;
			cost_q   <= '0;
			inl_q    <= '0;
			pts_q    <= '0;
			blk_q    <= '0;
			climit_q <= '0;
			cntlim_q <= '0;
			en_q     <= 1'b0;
			guard_q  <= 1'b0;
			closed_q <= 1'b0;
			tag_v_s1 <= 1'b0;
		end else begin
			tag_v_s1 <= (state_q == S_MUL);
			if (s_fire) begin
				unique case (s_tuser)
					FUNC_START: begin
						climit_q <= in_value;
						cntlim_q <= in_ilim;
						en_q     <= in_limen;
						guard_q  <= in_guard;
						closed_q <= 1'b0;
						cost_q   <= '0;
						inl_q    <= '0;
						pts_q    <= '0;
						blk_q    <= '0;
					end
					FUNC_LOAD: if (in_entry < 4'd12) pose_q[in_entry] <= in_value[31:0];
					default: ;
				endcase
			end
			if (state_q == S_ACC) begin
				cost_q <= csum[63] ? {63{1'b1}} : csum[62:0];
				inl_q  <= inl_q + 13'(inlier);
				pts_q  <= pts_q + 13'd1;
				blk_q  <= blk_q + 13'd1;
			end
			if (state_q == S_DEC) begin
				if (boundary) blk_q <= '0;
				if (boundary && (prune || pass_end)) closed_q <= 1'b1;
			end
		end
	end

	// ---------------- per-point datapath ----------------
	always_ff @(posedge clk) begin
		tag_row_s1 <= row_q;
		if (s_fire) begin
			img_x_q <= in_img_x;
			img_y_q <= in_img_y;
			w_q[0]  <= in_wx;
			w_q[1]  <= in_wy;
			w_q[2]  <= in_wz;
			last_q  <= s_tlast;
			row_q   <= 2'd0;
			col_q   <= 2'd0;
			// translation in Q.32 seeds each row sum
			for (int r = 0; r < 3; r++) begin
				z_q[r] <= {{4{pose_q[4*r+3][31]}}, pose_q[4*r+3], 16'b0};
			end
		end else begin
			if (state_q == S_MUL) begin
				if (col_q == 2'd2) begin
					col_q <= 2'd0;
					row_q <= row_q + 2'd1;
				end else begin
					col_q <= col_q + 2'd1;
				end
			end
			// floor(R*w / 2^14) folded into the row sum
			if (tag_v_s1) z_q[tag_row_s1] <= z_q[tag_row_s1] + prod_q[65:14];
		end
		if (state_q == S_ZCHK) zpos_q <= !z_q[2][Z_W-1] && (z_q[2] != '0);
		if (state_q == S_SQX || state_q == S_SQY) big_q <= (rmag[42:31] != '0);
		if (state_q == S_DYS) tx_q <= term;
		if (state_q == S_SQW) ty_q <= term;
		if (state_q == S_ZCHK) begin
			tx_q <= '0;
			ty_q <= '0;
		end
		if (state_q == S_DEC) prune_q <= prune;
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && (!out_valid_q || m_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || m_tready)) begin
			out_score_q <= cost_q;
			out_inl_q   <= inl_q;
			out_pts_q   <= pts_q;
			out_prune_q <= prune_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_pts_q, out_inl_q, out_score_q};
	assign m_tuser  = out_prune_q;

	// ---------------- assertions ----------------
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_FIN))
		else $error("result appeared without a finish step");

	a_mul_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (row_q <= 2'd2 && col_q <= 2'd2))
		else $error("multiply sequencer out of range");

	a_div_sat: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (drsp.q <= {1'b1, 40'b0}))
		else $error("projection quotient above saturation");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && s_tvalid && s_tuser == FUNC_POINT && !closed_q)
		|=> !s_tready)
		else $error("accepted an item during point scoring");
endmodule
`default_nettype wire
